// ----- rtl/vne_pkg.sv -----
// Shared widths, register indexes, neighbor item type and offset masks.
`timescale 1ns / 1ps
`default_nettype none

package vne_pkg;

  // Voxel index width and configuration port geometry.
  localparam int IDX_W     = 30;
  localparam int REG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  // Quotient bits resolved in each divider stage.
  localparam int DIV_STEP = 2;

  // Offset codes: code = 9*(dx+1) + 3*(dy+1) + (dz+1), walked from low to high.
  localparam int NBR_CODES = 27;

  // Axis selectors for digit_mask.
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  // Set of codes whose digit on one axis equals the given digit (0 = -1, 1 = 0, 2 = +1).
  function automatic logic [NBR_CODES-1:0] digit_mask(input int axis, input int digit);
    logic [NBR_CODES-1:0] m;
    int d;
    m = '0;
    for (int c = 0; c < NBR_CODES; c++) begin
      case (axis)
        AXIS_X:  d = c / 9;
        AXIS_Y:  d = (c / 3) % 3;
        default: d = c % 3;
      endcase
      if (d == digit) m[c] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [NBR_CODES-1:0] DX_NEG = digit_mask(AXIS_X, 0);
  localparam logic [NBR_CODES-1:0] DX_POS = digit_mask(AXIS_X, 2);
  localparam logic [NBR_CODES-1:0] DY_NEG = digit_mask(AXIS_Y, 0);
  localparam logic [NBR_CODES-1:0] DY_POS = digit_mask(AXIS_Y, 2);
  localparam logic [NBR_CODES-1:0] DZ_NEG = digit_mask(AXIS_Z, 0);
  localparam logic [NBR_CODES-1:0] DZ_POS = digit_mask(AXIS_Z, 2);
  localparam logic [NBR_CODES-1:0] CENTER_MASK =
    digit_mask(AXIS_X, 1) & digit_mask(AXIS_Y, 1) & digit_mask(AXIS_Z, 1);

  // One center voxel ready for enumeration: its linear index and the in-grid offsets.
  typedef struct packed {
    logic [IDX_W-1:0]     center;
    logic [NBR_CODES-1:0] mask;
  } nbr_item_t;

endpackage

`default_nettype wire

// ----- rtl/vne_in_if.sv -----
// Request channel carrying the center voxel index.
`timescale 1ns / 1ps
`default_nettype none

interface vne_in_if import vne_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] voxel_index;

  modport source (output valid, output voxel_index, input ready);
  modport sink   (input valid, input voxel_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/vne_out_if.sv -----
// Result channel carrying one neighbor index and the last flag.
`timescale 1ns / 1ps
`default_nettype none

interface vne_out_if import vne_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] neighbor_index;
  logic             last_neighbor;

  modport source (output valid, output neighbor_index, output last_neighbor, input ready);
  modport sink   (input valid, input neighbor_index, input last_neighbor, output ready);
endinterface

`default_nettype wire

// ----- rtl/voxel_neighbor_enumerator.sv -----
// An accepted request passes 45 divider stages, 2 index stages, the enumerator load and
// the output register; its results (26 for an interior voxel) leave one per cycle while
// the output is ready. With one result port, the enumerator takes a new request only when
// idle or with the last result; the front pipeline takes one per cycle unless stalled.
// Reset: synchronous; clears all valid bits and sets every grid extent to 1.
`timescale 1ns / 1ps
`default_nettype none

module voxel_neighbor_enumerator import vne_pkg::*; #(
  parameter int DIM_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  vne_in_if.sink               voxel_in,
  vne_out_if.source            neighbor_out
);

  localparam int          EXT_W      = (DIM_BITS + 1 < REG_W) ? DIM_BITS + 1 : REG_W;
  localparam int          SIDE_W     = 2 * EXT_W;
  localparam logic [31:0] EXT_LIMIT  = 32'd1 << DIM_BITS;

  // Effective extents, clamped to 1..2^DIM_BITS when written.
  logic [EXT_W-1:0]   nx, ny, nz;
  logic [EXT_W-1:0]   cfg_eff;
  logic [2*EXT_W-1:0] nxy;

  logic               advance;
  logic               tail_valid;
  logic               enum_ready;
  nbr_item_t          tail_item;

  logic               v1, v2, v3;
  logic [IDX_W-1:0]   q1, q2;
  logic [EXT_W-1:0]   r1, r2, r3;
  logic [SIDE_W-1:0]  s2, s3;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_eff = EXT_W'(1);
    end else if (32'(cfg_data) > EXT_LIMIT) begin
      cfg_eff = EXT_W'(EXT_LIMIT);
    end else begin
      cfg_eff = EXT_W'(cfg_data);
    end
  end

  // Extent registers; writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      nx <= EXT_W'(1);
      ny <= EXT_W'(1);
      nz <= EXT_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SIZE_X: nx <= cfg_eff;
        REG_SIZE_Y: ny <= cfg_eff;
        REG_SIZE_Z: nz <= cfg_eff;
        default: ;
      endcase
    end
  end

  // Slice stride, nx * ny.
  always_ff @(posedge clk) begin
    nxy <= (2 * EXT_W)'(nx) * (2 * EXT_W)'(ny);
  end

  // The front pipeline moves as a whole whenever its tail is free or taken.
  assign advance        = !tail_valid || enum_ready;
  assign voxel_in.ready = advance;

  // x = idx mod nx, q1 = idx / nx.
  vne_div_pipe #(.DEN_W(EXT_W), .SIDE_W(SIDE_W)) u_div_x (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_valid      (voxel_in.valid),
    .in_dividend   (voxel_in.voxel_index),
    .in_side       ('0),
    .divisor       (nx),
    .out_valid     (v1),
    .out_quotient  (q1),
    .out_remainder (r1),
    .out_side      ()
  );

  // y = q1 mod ny, q2 = q1 / ny.
  vne_div_pipe #(.DEN_W(EXT_W), .SIDE_W(SIDE_W)) u_div_y (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_valid      (v1),
    .in_dividend   (q1),
    .in_side       ({r1, {EXT_W{1'b0}}}),
    .divisor       (ny),
    .out_valid     (v2),
    .out_quotient  (q2),
    .out_remainder (r2),
    .out_side      (s2)
  );

  // z = q2 mod nz.
  vne_div_pipe #(.DEN_W(EXT_W), .SIDE_W(SIDE_W)) u_div_z (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_valid      (v2),
    .in_dividend   (q2),
    .in_side       ({s2[SIDE_W-1:EXT_W], r2}),
    .divisor       (nz),
    .out_valid     (v3),
    .out_quotient  (),
    .out_remainder (r3),
    .out_side      (s3)
  );

  vne_center #(.EXT_W(EXT_W)) u_center (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (v3),
    .x         (s3[SIDE_W-1:EXT_W]),
    .y         (s3[EXT_W-1:0]),
    .z         (r3),
    .nx        (nx),
    .ny        (ny),
    .nz        (nz),
    .out_valid (tail_valid),
    .out_item  (tail_item)
  );

  vne_enum #(.EXT_W(EXT_W)) u_enum (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tail_valid),
    .in_item  (tail_item),
    .in_ready (enum_ready),
    .nx       (nx),
    .nxy      (nxy),
    .nbr_out  (neighbor_out)
  );

endmodule

`default_nettype wire

// ----- rtl/vne_div_pipe.sv -----
// Pipelined restoring divider of a voxel-index-wide dividend by a grid extent.
`timescale 1ns / 1ps
`default_nettype none

module vne_div_pipe import vne_pkg::*; #(
  parameter int DEN_W  = 11,
  parameter int SIDE_W = 22
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  logic [IDX_W-1:0]  in_dividend,
  input  logic [SIDE_W-1:0] in_side,
  input  logic [DEN_W-1:0]  divisor,
  output logic              out_valid,
  output logic [IDX_W-1:0]  out_quotient,
  output logic [DEN_W-1:0]  out_remainder,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STAGES = IDX_W / DIV_STEP;

  // Each stage shifts dividend bits out of the top of work and quotient bits in at the bottom.
  logic              valid [STAGES];
  logic [IDX_W-1:0]  work  [STAGES];
  logic [DEN_W-1:0]  rem   [STAGES];
  logic [SIDE_W-1:0] side  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic              v_in;
    logic [IDX_W-1:0]  w_in;
    logic [DEN_W-1:0]  r_in;
    logic [SIDE_W-1:0] s_in;
    logic [IDX_W-1:0]  work_next;
    logic [DEN_W-1:0]  rem_next;

    if (s == 0) begin : g_head
      assign v_in = in_valid;
      assign w_in = in_dividend;
      assign r_in = '0;
      assign s_in = in_side;
    end else begin : g_body
      assign v_in = valid[s-1];
      assign w_in = work[s-1];
      assign r_in = rem[s-1];
      assign s_in = side[s-1];
    end

    // Resolve DIV_STEP quotient bits by shift, compare and subtract.
    always_comb begin : p_step
      logic [DEN_W:0] trial;
      work_next = w_in;
      rem_next  = r_in;
      for (int b = 0; b < DIV_STEP; b++) begin
        trial     = {rem_next, work_next[IDX_W-1]};
        work_next = {work_next[IDX_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          trial        = trial - {1'b0, divisor};
          work_next[0] = 1'b1;
        end
        rem_next = trial[DEN_W-1:0];
      end
    end

    // Valid bit travels with the data.
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (advance) begin
        valid[s] <= v_in;
      end
    end

    // Payload registers.
    always_ff @(posedge clk) begin
      if (advance) begin
        work[s] <= work_next;
        rem[s]  <= rem_next;
        side[s] <= s_in;
      end
    end
  end

  assign out_valid     = valid[STAGES-1];
  assign out_quotient  = work[STAGES-1];
  assign out_remainder = rem[STAGES-1];
  assign out_side      = side[STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/vne_center.sv -----
// Two-stage rebuild of the in-grid center index and its valid-offset mask.
`timescale 1ns / 1ps
`default_nettype none

module vne_center import vne_pkg::*; #(
  parameter int EXT_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  input  logic [EXT_W-1:0] x,
  input  logic [EXT_W-1:0] y,
  input  logic [EXT_W-1:0] z,
  input  logic [EXT_W-1:0] nx,
  input  logic [EXT_W-1:0] ny,
  input  logic [EXT_W-1:0] nz,
  output logic             out_valid,
  output nbr_item_t        out_item
);

  localparam int T_W = 2 * EXT_W;
  localparam int P_W = 3 * EXT_W;

  logic                 valid1;
  logic [T_W-1:0]       row;
  logic [EXT_W-1:0]     x1;
  logic [NBR_CODES-1:0] mask1;

  logic                 valid2;
  nbr_item_t            item2;

  logic [T_W-1:0]       row_prod;
  logic [T_W-1:0]       row_next;
  logic [P_W-1:0]       lin_prod;
  logic [NBR_CODES-1:0] mask_next;
  logic                 ok_xn, ok_xp, ok_yn, ok_yp, ok_zn, ok_zp;

  // Which single-axis moves stay inside the grid.
  assign ok_xn = (x != '0);
  assign ok_xp = (x < (nx - EXT_W'(1)));
  assign ok_yn = (y != '0);
  assign ok_yp = (y < (ny - EXT_W'(1)));
  assign ok_zn = (z != '0);
  assign ok_zp = (z < (nz - EXT_W'(1)));

  // Offsets allowed on all three axes, the voxel itself excluded.
  assign mask_next = (~DX_NEG | {NBR_CODES{ok_xn}}) & (~DX_POS | {NBR_CODES{ok_xp}})
                   & (~DY_NEG | {NBR_CODES{ok_yn}}) & (~DY_POS | {NBR_CODES{ok_yp}})
                   & (~DZ_NEG | {NBR_CODES{ok_zn}}) & (~DZ_POS | {NBR_CODES{ok_zp}})
                   & ~CENTER_MASK;

  // Stage one: row number ny * z + y.
  assign row_prod = T_W'(ny) * T_W'(z);
  assign row_next = row_prod + T_W'(y);

  // Stage two: linear index nx * row + x.
  assign lin_prod = P_W'(nx) * P_W'(row);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else if (advance) begin
      valid1 <= in_valid;
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      row          <= row_next;
      x1           <= x;
      mask1        <= mask_next;
      item2.center <= IDX_W'(lin_prod + P_W'(x1));
      item2.mask   <= mask1;
    end
  end

  assign out_valid = valid2;
  assign out_item  = item2;

endmodule

`default_nettype wire

// ----- rtl/vne_enum.sv -----
// Emits the valid-offset neighbors of one center voxel, one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module vne_enum import vne_pkg::*; #(
  parameter int EXT_W = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  nbr_item_t          in_item,
  output logic               in_ready,
  input  logic [EXT_W-1:0]   nx,
  input  logic [2*EXT_W-1:0] nxy,
  vne_out_if.source          nbr_out
);

  logic [NBR_CODES-1:0] cur_mask;
  logic [IDX_W-1:0]     cur_center;
  logic                 out_valid;
  logic [IDX_W-1:0]     out_index;
  logic                 out_last;

  logic [NBR_CODES-1:0] sel;
  logic [NBR_CODES-1:0] rest;
  logic                 emit;
  logic                 last;
  logic [IDX_W-1:0]     step_x, step_y, step_z;
  logic [IDX_W-1:0]     nx_ext, nxy_ext;
  logic [IDX_W-1:0]     nbr_index;

  // Lowest pending offset code, as a one-hot word.
  assign sel  = cur_mask & (~cur_mask + NBR_CODES'(1));
  assign rest = cur_mask & ~sel;
  assign last = (rest == '0);

  // A result moves into the output register when it is empty or being drained.
  assign emit     = (cur_mask != '0) && (!out_valid || nbr_out.ready);
  assign in_ready = (cur_mask == '0) || (emit && last);

  // Index deltas of the selected offset along each axis.
  assign nx_ext  = IDX_W'(nx);
  assign nxy_ext = IDX_W'(nxy);

  always_comb begin
    step_x = '0;
    step_y = '0;
    step_z = '0;
    if ((sel & DX_NEG) != '0) step_x = '1;
    if ((sel & DX_POS) != '0) step_x = IDX_W'(1);
    if ((sel & DY_NEG) != '0) step_y = IDX_W'(0) - nx_ext;
    if ((sel & DY_POS) != '0) step_y = nx_ext;
    if ((sel & DZ_NEG) != '0) step_z = IDX_W'(0) - nxy_ext;
    if ((sel & DZ_POS) != '0) step_z = nxy_ext;
  end

  assign nbr_index = cur_center + step_x + step_y + step_z;

  // Pending-offset mask of the current center voxel.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask <= '0;
    end else if (in_valid && in_ready) begin
      cur_mask <= in_item.mask;
    end else if (emit) begin
      cur_mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_center <= in_item.center;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (nbr_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_index <= nbr_index;
      out_last  <= last;
    end
  end

  assign nbr_out.valid          = out_valid;
  assign nbr_out.neighbor_index = out_index;
  assign nbr_out.last_neighbor  = out_last;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the 26-connected voxel neighbor enumerator.
`timescale 1ns / 1ps
`default_nettype none

module tb_top import vne_pkg::*; ();

  localparam int DIM_BITS = 10;
  localparam longint GRID_MAX = longint'(1) << DIM_BITS;
  // The register space has four slots but only three registers.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  // Request-to-output latency of the block plus some margin.
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 29;
  localparam int RAND_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 17;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
  } nbr_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  vne_in_if  voxel_if ();
  vne_out_if nbr_if ();

  voxel_neighbor_enumerator #(
    .DIM_BITS(DIM_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .voxel_in(voxel_if.sink),
    .neighbor_out(nbr_if.source)
  );

  // Mirror of the grid registers and the checking state.
  logic [REG_W-1:0] grid_reg [3];
  logic [IDX_W-1:0] pending_voxels [$];
  nbr_t expected_neighbors [$];
  bit steady;
  int errors;
  int requests_sent;
  int results_checked;
  int empty_requests;
  int wrapped_requests;
  int grid_settings;
  int cycle_count;

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Append one voxel to the stimulus queue.
  function automatic void add_voxel(input logic [IDX_W-1:0] v);
    pending_voxels = {pending_voxels, v};
  endfunction

  // Effective extent: zero acts as one, oversized values clamp to the grid limit.
  function automatic longint grid_extent(input logic [REG_W-1:0] r);
    if (r == '0) return 1;
    if (longint'(r) > GRID_MAX) return GRID_MAX;
    return longint'(r);
  endfunction

  // Expected neighbors of one center voxel, dx outermost and dz innermost.
  function automatic void predict_neighbors(input logic [IDX_W-1:0] center);
    longint nx, ny, nz, c, x, y, z, xx, yy, zz;
    nbr_t n;
    nbr_t found [$];
    nx = grid_extent(grid_reg[REG_SIZE_X]);
    ny = grid_extent(grid_reg[REG_SIZE_Y]);
    nz = grid_extent(grid_reg[REG_SIZE_Z]);
    c = longint'(center);
    x = c % nx;
    y = (c / nx) % ny;
    z = (c / (nx * ny)) % nz;
    if (c >= nx * ny * nz) wrapped_requests++;
    for (int dx = -1; dx <= 1; dx++) begin
      xx = x + dx;
      if (xx < 0 || xx >= nx) continue;
      for (int dy = -1; dy <= 1; dy++) begin
        yy = y + dy;
        if (yy < 0 || yy >= ny) continue;
        for (int dz = -1; dz <= 1; dz++) begin
          zz = z + dz;
          if (zz < 0 || zz >= nz) continue;
          if (dx == 0 && dy == 0 && dz == 0) continue;
          n.index = IDX_W'(nx * (ny * zz + yy) + xx);
          n.last = 1'b0;
          found = {found, n};
        end
      end
    end
    if (found.size() == 0) begin
      empty_requests++;
    end else begin
      found[found.size()-1].last = 1'b1;
    end
    expected_neighbors = {expected_neighbors, found};
  endfunction

  // Register write on the configuration port; the mirror ignores unused slots.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_SIZE_X: grid_reg[REG_SIZE_X] = data;
      REG_SIZE_Y: grid_reg[REG_SIZE_Y] = data;
      REG_SIZE_Z: grid_reg[REG_SIZE_Z] = data;
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [REG_W-1:0] sx, input logic [REG_W-1:0] sy,
                          input logic [REG_W-1:0] sz);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    grid_settings++;
  endtask

  // Hold until every request is in and every neighbor is out, then let the pipe empty.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_voxels.size() != 0 || voxel_if.valid || expected_neighbors.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly small extents, with zero, the limit and oversized values mixed in.
  function automatic logic [REG_W-1:0] pick_extent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return REG_W'($urandom_range(GRID_MAX + 1, (1 << REG_W) - 1));
      2: return REG_W'(GRID_MAX);
      3: return REG_W'($urandom);
      default: return REG_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic longint pick_coord(input longint n);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return n - 1;
      default: return longint'($urandom_range(0, int'(n - 1)));
    endcase
  endfunction

  // Mostly in-grid centers biased toward faces and corners, some raw indexes.
  function automatic logic [IDX_W-1:0] pick_voxel();
    longint nx, ny, nz, x, y, z;
    nx = grid_extent(grid_reg[REG_SIZE_X]);
    ny = grid_extent(grid_reg[REG_SIZE_Y]);
    nz = grid_extent(grid_reg[REG_SIZE_Z]);
    if ($urandom_range(0, 4) == 0) return IDX_W'($urandom);
    x = pick_coord(nx);
    y = pick_coord(ny);
    z = pick_coord(nz);
    return IDX_W'(nx * (ny * z + y) + x);
  endfunction

  // Request driver: predicts on acceptance and presents the next voxel.
  always @(posedge clk) begin
    if (rst) begin
      voxel_if.valid <= 1'b0;
    end else begin
      if (voxel_if.valid && voxel_if.ready) begin
        predict_neighbors(voxel_if.voxel_index);
        requests_sent++;
      end
      if (!voxel_if.valid || voxel_if.ready) begin
        if (pending_voxels.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          voxel_if.valid <= 1'b1;
          voxel_if.voxel_index <= pending_voxels.pop_front();
        end else begin
          voxel_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted neighbor with the oldest expectation.
  always @(posedge clk) begin : result_check
    nbr_t want;
    if (rst) begin
      nbr_if.ready <= 1'b0;
    end else begin
      if (nbr_if.valid && nbr_if.ready) begin
        if (expected_neighbors.size() == 0) begin
          $display("%0t: expected no neighbor, actual neighbor index %0d last %0b", $time,
                   nbr_if.neighbor_index, nbr_if.last_neighbor);
          errors++;
        end else begin
          want = expected_neighbors.pop_front();
          results_checked++;
          if (nbr_if.neighbor_index !== want.index) begin
            $display("%0t: neighbor_index expected %0d actual %0d", $time, want.index,
                     nbr_if.neighbor_index);
            errors++;
          end
          if (nbr_if.last_neighbor !== want.last) begin
            $display("%0t: last_neighbor expected %0b actual %0b", $time, want.last,
                     nbr_if.last_neighbor);
            errors++;
          end
        end
      end
      nbr_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** voxel_neighbor_enumerator: FAILED **");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    voxel_if.valid = 1'b0;
    voxel_if.voxel_index = '0;
    nbr_if.ready = 1'b0;
    steady = 1'b0;
    errors = 0;
    requests_sent = 0;
    results_checked = 0;
    empty_requests = 0;
    wrapped_requests = 0;
    grid_settings = 1;
    cycle_count = 0;
    foreach (grid_reg[i]) grid_reg[i] = REG_W'(1);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Single-voxel grid after reset: nothing comes out, even for the top index.
    add_voxel('0);
    add_voxel('1);
    wait_drained();

    // Small cube: interior, corners, an edge and a face center.
    set_grid(11'd3, 11'd3, 11'd3);
    add_voxel(IDX_W'(13));
    add_voxel(IDX_W'(0));
    add_voxel(IDX_W'(26));
    add_voxel(IDX_W'(1));
    add_voxel(IDX_W'(4));
    wait_drained();

    // Largest grid: the full index range is inside.
    set_grid(REG_W'(GRID_MAX), REG_W'(GRID_MAX), REG_W'(GRID_MAX));
    add_voxel('0);
    add_voxel('1);
    add_voxel({10'd512, 10'd512, 10'd512});
    wait_drained();

    // Zero extent and oversized extent; an index beyond the grid wraps in z.
    set_grid(11'd0, 11'h7FF, 11'd5);
    add_voxel(IDX_W'(1023));
    add_voxel('1);
    wait_drained();

    // A write to the unused register slot must leave the grid as it is.
    write_reg(REG_NONE, 11'h7FF);
    add_voxel(IDX_W'(2048));
    wait_drained();

    // Degenerate lines along x and along z.
    set_grid(11'd2, 11'd1, 11'd1);
    add_voxel(IDX_W'(0));
    add_voxel(IDX_W'(1));
    wait_drained();
    set_grid(11'd1, 11'd1, 11'd2);
    add_voxel(IDX_W'(1));
    wait_drained();

    // Random grids and centers; one phase runs without any idling.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      set_grid(pick_extent(), pick_extent(), pick_extent());
      if (phase == 2) write_reg(REG_NONE, REG_W'($urandom));
      steady = (phase == 3);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) add_voxel(pick_voxel());
      wait_drained();
      steady = 1'b0;
    end

    $display("Run covered %0d voxel requests over %0d grid settings, %0d of them wrapped.",
             requests_sent, grid_settings, wrapped_requests);
    $display("Checked %0d neighbor results; %0d requests had no neighbors.",
             results_checked, empty_requests);
    if (errors == 0) begin
      $display("** voxel_neighbor_enumerator: PASSED **");
    end else begin
      $display("** voxel_neighbor_enumerator: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
